>>> hdl/wbss_pkg.sv
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared constants and types for the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
package wbss_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int OFFSET_BITS = 32;
	localparam int COUNT_BITS  = OFFSET_BITS + 1;
	localparam int LEN_BITS    = 5;
	localparam int IDX_BITS    = 4;

	// configuration register indexes (byte address = 8 * index)
	localparam logic [1:0] REG_PAT_LO = 2'd0;
	localparam logic [1:0] REG_PAT_HI = 2'd1;
	localparam logic [1:0] REG_WILD   = 2'd2;
	localparam logic [1:0] REG_LEN    = 2'd3;

	typedef logic [7:0] byte_t;
	typedef byte_t [MAX_PATTERN-1:0] window_t;

endpackage

>>> hdl/wildcard_byte_signature_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan
// Streams image bytes and reports the first offset where a masked pattern of
// up to 16 bytes matches, or not-found on the last byte of the image.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  data     | data_valid   | data_stall   | data_byte, last_byte
//  result   | result_valid | result_stall | found, match_offset
//  config   | psel/penable | pready (=1)  | paddr, pwrite, pwdata, prdata
//
//  One byte per cycle sustained while the result is not stalled.
//  Input register, then a single compare stage (16 masked byte compares)
//  that updates the window and counter and loads the result register.
//  Reset clears the window, counter and report flag; pattern length resets to 1.
//  A stalled result holds the compare stage for every byte, result or not;
//  the input stalls once the input register is full behind it.
module wildcard_byte_signature_scan
	import wbss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   data_valid,
	output logic                   data_stall,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   found,
	output logic [OFFSET_BITS-1:0] match_offset,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [63:0]            pwdata,
	output logic [63:0]            prdata,
	output logic                   pready
);

	logic [63:0]            pat_lo_q, pat_hi_q;
	logic [MAX_PATTERN-1:0] wild_q;
	logic [LEN_BITS-1:0]    len_cfg_q;

	logic [LEN_BITS-1:0]    len_q;
	window_t                exp_q;
	logic [MAX_PATTERN-1:0] care_q;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;

	window_t                window_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic                   reported_q;

	logic                   res_valid_q;
	logic                   found_q;
	logic [OFFSET_BITS-1:0] offset_q;

	logic                   cfg_wr, accept, adv, hit, emit;
	logic [1:0]             cfg_idx;
	logic [LEN_BITS-1:0]    len_c;
	window_t                pat_c, exp_c, window_nx;
	logic [MAX_PATTERN-1:0] care_c;
	logic [COUNT_BITS-1:0]  cnt_nx, off_full;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:3];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			wild_q    <= '0;
			len_cfg_q <= LEN_BITS'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PAT_LO: pat_lo_q  <= pwdata;
				REG_PAT_HI: pat_hi_q  <= pwdata;
				REG_WILD:   wild_q    <= pwdata[MAX_PATTERN-1:0];
				REG_LEN:    len_cfg_q <= pwdata[LEN_BITS-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PAT_LO: prdata = pat_lo_q;
			REG_PAT_HI: prdata = pat_hi_q;
			REG_WILD:   prdata = {{(64-MAX_PATTERN){1'b0}}, wild_q};
			REG_LEN:    prdata = {{(64-LEN_BITS){1'b0}}, len_cfg_q};
			default:    prdata = '0;
		endcase
	end

	// ---------------- pattern alignment ----------------
	// Window slot k (0 = newest) is compared against pattern byte len-1-k.
	always_comb begin
		logic [LEN_BITS-1:0] j;
		if (len_cfg_q == '0)
			len_c = LEN_BITS'(1);
		else if (len_cfg_q > LEN_BITS'(MAX_PATTERN))
			len_c = LEN_BITS'(MAX_PATTERN);
		else
			len_c = len_cfg_q;
		pat_c = window_t'({pat_hi_q, pat_lo_q});
		for (int k = 0; k < MAX_PATTERN; k++) begin
			j = len_c - LEN_BITS'(1) - LEN_BITS'(k);
			exp_c[k] = pat_c[j[IDX_BITS-1:0]];
			care_c[k] = (LEN_BITS'(k) < len_c) && !wild_q[j[IDX_BITS-1:0]];
		end
	end

	// User, not the block, keeps config static while items are in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_BITS'(1);
			care_q <= '0;
		end else begin
			len_q  <= len_c;
			care_q <= care_c;
		end
	end

	always_ff @(posedge clk) begin
		exp_q <= exp_c;
	end

	// ---------------- input register ----------------
	assign adv        = valid_s1 && (!res_valid_q || !result_stall);
	assign data_stall = valid_s1 && res_valid_q && result_stall;
	assign accept     = data_valid && !data_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// ---------------- compare stage ----------------
	always_comb begin
		window_nx = {window_q[MAX_PATTERN-2:0], byte_s1};
		cnt_nx    = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
		hit       = !reported_q && (cnt_nx >= COUNT_BITS'(len_q));
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (care_q[k] && (window_nx[k] != exp_q[k]))
				hit = 1'b0;
		end
		emit     = hit || (last_s1 && !reported_q);
		off_full = cnt_nx - COUNT_BITS'(len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			cnt_q      <= '0;
			reported_q <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				window_q   <= '0;
				cnt_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				window_q <= window_nx;
				cnt_q    <= cnt_nx;
				if (hit)
					reported_q <= 1'b1;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv && emit)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			found_q <= hit;
			if (!hit)
				offset_q <= '0;
			else if (off_full[COUNT_BITS-1])
				offset_q <= '1;
			else
				offset_q <= off_full[OFFSET_BITS-1:0];
		end
	end

	assign result_valid = res_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

	// ---------------- assertions ----------------
	a_nf_zero_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !found_q |-> offset_q == '0)
		else $error("not-found transaction carries nonzero offset");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> valid_s1 && res_valid_q)
		else $error("input stalled with no pending work");

	a_rep_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		reported_q |-> cnt_q != '0)
		else $error("match reported with empty byte count");

	a_last_clr: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> cnt_q == '0 && !reported_q)
		else $error("scan state not cleared after last byte");

endmodule
